/* src/scbc_pkg.sv */
// Shared types and constants of the size-class block cache.
package scbc_pkg;

    // Fixed field widths
    localparam int KIND_W     = 2;
    localparam int SIZE_W     = 24;
    localparam int CLASS_W    = 25;
    localparam int HELD_W     = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE_SIZED = 2'd1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CACHE_ENABLED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BUDGET_BYTES  = 2'd1;

    // Register reset values
    localparam logic              ENABLED_RESET = 1'b1;
    localparam logic [HELD_W-1:0] BUDGET_RESET  = 18'd131072;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;
        logic pass;
        logic push;
        logic pop_read;
        logic pop_write;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic usable;
        logic is_alloc;
        logic hit;
        logic push_ok;
    } t_sts;

endpackage

/* src/scbc_req_if.sv */
// Request channel of the size-class block cache.
interface scbc_req_if #(
    parameter int ADDRESS_BITS = 48
);
    logic                            valid;
    logic                            ready;
    logic [scbc_pkg::KIND_W-1:0]     kind;
    logic [scbc_pkg::SIZE_W-1:0]     size_bytes;
    logic [ADDRESS_BITS-1:0]         block_address;

    modport source (output valid, kind, size_bytes, block_address, input ready);
    modport sink   (input valid, kind, size_bytes, block_address, output ready);
endinterface

/* src/scbc_rsp_if.sv */
// Response channel of the size-class block cache.
interface scbc_rsp_if #(
    parameter int ADDRESS_BITS = 48
);
    logic                            valid;
    logic                            ready;
    logic                            served;
    logic [ADDRESS_BITS-1:0]         block_out;
    logic [scbc_pkg::CLASS_W-1:0]    class_bytes;
    logic [scbc_pkg::HELD_W-1:0]     cached_total;

    modport source (output valid, served, block_out, class_bytes, cached_total, input ready);
    modport sink   (input valid, served, block_out, class_bytes, cached_total, output ready);
endinterface

/* src/size_class_block_cache.sv */
// Top level of the size-class block cache.
//
//  channel   dir  handshake        beat
//  i_req     in   valid / ready    kind, size_bytes, block_address
//  o_rsp     out  valid / ready    served, block_out, class_bytes, cached_total
//  i_cfg_*   in   i_cfg_we only    i_cfg_index, i_cfg_data (no read-back)
//
// One request at a time. A pass-through, miss or sized free goes through accept,
// bin look-up and result load, the load waiting while the output slot is full.
// An allocate hit adds a node step (S_NODE), since the bin head read
// and the node read are two dependent RAM reads before the write-back.
// Synchronous active-low reset empties every bin by valid bits and puts all
// nodes on the spare list through a fresh-node mark; no clearing pass.
// A stalled response holds in the output register; the next request is taken
// while it waits, and its result holds in the datapath until the slot frees.
module size_class_block_cache #(
    parameter int GRANULE_BYTES   = 128,
    parameter int MAX_CLASS_BYTES = 8192,
    parameter int BIN_COUNT       = 64,
    parameter int NODE_COUNT      = 1024,
    parameter int ADDRESS_BITS    = 48
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    scbc_req_if.sink                         i_req,
    scbc_rsp_if.source                       o_rsp,
    input  logic                             i_cfg_we,
    input  logic [scbc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [scbc_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    scbc_pkg::t_cmd cmd;
    scbc_pkg::t_sts sts;

    // Sequencer: accept, look up the bin, pop or push, deliver the beat
    scbc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Datapath: class rounding, bin heads, node address and link stores
    scbc_datapath #(
        .GRANULE_BYTES   (GRANULE_BYTES),
        .MAX_CLASS_BYTES (MAX_CLASS_BYTES),
        .BIN_COUNT       (BIN_COUNT),
        .NODE_COUNT      (NODE_COUNT),
        .ADDRESS_BITS    (ADDRESS_BITS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_req_kind     (i_req.kind),
        .i_req_size     (i_req.size_bytes),
        .i_req_addr     (i_req.block_address),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_served       (o_rsp.served),
        .o_block_out    (o_rsp.block_out),
        .o_class_bytes  (o_rsp.class_bytes),
        .o_cached_total (o_rsp.cached_total)
    );
endmodule

/* src/scbc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module scbc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

/* src/scbc_ctrl.sv */
// Sequencer of the size-class block cache: look up, pop or push, deliver.
module scbc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  scbc_pkg::t_sts   i_sts,
    output scbc_pkg::t_cmd   o_cmd
);
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_NODE,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_state    = r_state;
        case (r_state)
            S_IDLE: begin
                // hold off requests while reset is applied
                o_in_ready    = i_rst_n;
                o_cmd.capture = i_in_valid && i_rst_n;
                if (i_in_valid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                if (!i_sts.usable) begin
                    o_cmd.pass = 1'b1;
                    n_state    = S_DONE;
                end else if (i_sts.is_alloc) begin
                    if (i_sts.hit) begin
                        o_cmd.pop_read = 1'b1;
                        n_state        = S_NODE;
                    end else begin
                        o_cmd.pass = 1'b1;
                        n_state    = S_DONE;
                    end
                end else begin
                    if (i_sts.push_ok) begin
                        o_cmd.push = 1'b1;
                    end else begin
                        o_cmd.pass = 1'b1;
                    end
                    n_state = S_DONE;
                end
            end
            S_NODE: begin
                o_cmd.pop_write = 1'b1;
                n_state         = S_DONE;
            end
            S_DONE: begin
                o_cmd.load_out = !r_out_valid || i_out_ready;
                if (o_cmd.load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_pop_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.pop_read |=> o_cmd.pop_write)
        else $error("pop read not followed by pop write");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |=> r_out_valid)
        else $error("loaded result not presented");
endmodule

/* src/scbc_datapath.sv */
// Datapath of the size-class block cache: class rounding, bin and node stores.
module scbc_datapath #(
    parameter int GRANULE_BYTES   = 128,
    parameter int MAX_CLASS_BYTES = 8192,
    parameter int BIN_COUNT       = 64,
    parameter int NODE_COUNT      = 1024,
    parameter int ADDRESS_BITS    = 48
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  scbc_pkg::t_cmd                    i_cmd,
    output scbc_pkg::t_sts                    o_sts,
    input  logic [scbc_pkg::KIND_W-1:0]       i_req_kind,
    input  logic [scbc_pkg::SIZE_W-1:0]       i_req_size,
    input  logic [ADDRESS_BITS-1:0]           i_req_addr,
    input  logic                              i_cfg_we,
    input  logic [scbc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [scbc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic                              o_served,
    output logic [ADDRESS_BITS-1:0]           o_block_out,
    output logic [scbc_pkg::CLASS_W-1:0]      o_class_bytes,
    output logic [scbc_pkg::HELD_W-1:0]       o_cached_total
);
    localparam int CLASS_W = scbc_pkg::CLASS_W;
    localparam int HELD_W  = scbc_pkg::HELD_W;
    localparam int SUM_W   = CLASS_W + 1;
    localparam int GRAN_LG = $clog2(GRANULE_BYTES);
    localparam int BIN_AW  = $clog2(BIN_COUNT);
    localparam int NODE_W  = $clog2(NODE_COUNT + 1);
    localparam int NODE_AW = $clog2(NODE_COUNT);
    localparam logic [NODE_W-1:0] NO_NODE = NODE_W'(NODE_COUNT);

    // Class rounding on the incoming request
    logic [CLASS_W-1:0] size_nz;
    logic [CLASS_W-1:0] size_round;
    logic [CLASS_W-1:0] quot;
    logic [CLASS_W-1:0] cls;
    logic [CLASS_W-1:0] bin_full;
    logic [BIN_AW-1:0]  in_bin;
    logic               fits;
    logic               is_alloc;
    logic               is_sized;

    assign size_nz    = (i_req_size == '0) ? CLASS_W'(1) : CLASS_W'(i_req_size);
    assign size_round = size_nz + CLASS_W'(GRANULE_BYTES - 1);
    assign quot       = size_round >> GRAN_LG;
    assign cls        = quot << GRAN_LG;
    assign bin_full   = quot - CLASS_W'(1);
    assign in_bin     = bin_full[BIN_AW-1:0];
    assign fits       = (cls <= CLASS_W'(MAX_CLASS_BYTES)) && (quot <= CLASS_W'(BIN_COUNT));
    assign is_alloc   = (i_req_kind == scbc_pkg::KIND_ALLOC);
    assign is_sized   = is_alloc || (i_req_kind == scbc_pkg::KIND_FREE_SIZED);

    // Registers
    logic                    r_enabled;
    logic [HELD_W-1:0]       r_budget;
    logic [HELD_W-1:0]       r_held;
    logic [NODE_W-1:0]       r_spare;
    logic [NODE_W-1:0]       r_fresh;
    logic [BIN_COUNT-1:0]    r_bin_valid;
    logic                    r_alloc;
    logic                    r_usable;
    logic [CLASS_W-1:0]      r_cls;
    logic [CLASS_W-1:0]      r_cls_out;
    logic [BIN_AW-1:0]       r_bin;
    logic [ADDRESS_BITS-1:0] r_addr;
    logic                    r_head_valid;
    logic [NODE_W-1:0]       r_head;
    logic                    r_res_served;
    logic [ADDRESS_BITS-1:0] r_res_block;
    logic                    r_served;
    logic [ADDRESS_BITS-1:0] r_block_out;
    logic [CLASS_W-1:0]      r_class_bytes;
    logic [HELD_W-1:0]       r_cached_total;

    // Memory ports
    logic [NODE_W-1:0]       bin_rdata;
    logic [NODE_W-1:0]       link_rdata;
    logic [ADDRESS_BITS-1:0] addr_rdata;
    logic                    bin_we;
    logic [NODE_W-1:0]       bin_wdata;
    logic                    link_we;
    logic                    link_re;
    logic [NODE_AW-1:0]      link_waddr;
    logic [NODE_AW-1:0]      link_raddr;
    logic [NODE_W-1:0]       link_wdata;

    logic [NODE_W-1:0]       head;
    logic [SUM_W-1:0]        held_sum;
    logic                    spare_fresh;
    logic [HELD_W-1:0]       held_less;

    assign head        = r_head_valid ? bin_rdata : NO_NODE;
    assign held_sum    = SUM_W'(r_held) + SUM_W'(r_cls);
    assign spare_fresh = (r_spare >= r_fresh);
    assign held_less   = (CLASS_W'(r_held) >= r_cls) ? (r_held - r_cls[HELD_W-1:0]) : '0;

    assign o_sts.usable   = r_usable;
    assign o_sts.is_alloc = r_alloc;
    assign o_sts.hit      = (head < NO_NODE);
    assign o_sts.push_ok  = (held_sum <= SUM_W'(r_budget)) && (r_spare < NO_NODE);

    assign bin_we     = i_cmd.push || i_cmd.pop_write;
    assign bin_wdata  = i_cmd.push ? r_spare : link_rdata;
    assign link_we    = i_cmd.push || i_cmd.pop_write;
    assign link_waddr = i_cmd.push ? r_spare[NODE_AW-1:0] : r_head[NODE_AW-1:0];
    assign link_wdata = i_cmd.push ? head : r_spare;
    assign link_re    = i_cmd.capture || i_cmd.pop_read;
    assign link_raddr = i_cmd.pop_read ? head[NODE_AW-1:0] : r_spare[NODE_AW-1:0];

    scbc_ram #(.WIDTH(NODE_W), .DEPTH(BIN_COUNT)) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (r_bin),
        .i_wdata (bin_wdata),
        .i_re    (i_cmd.capture),
        .i_raddr (in_bin),
        .o_rdata (bin_rdata)
    );

    scbc_ram #(.WIDTH(NODE_W), .DEPTH(NODE_COUNT)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    scbc_ram #(.WIDTH(ADDRESS_BITS), .DEPTH(NODE_COUNT)) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.push),
        .i_waddr (r_spare[NODE_AW-1:0]),
        .i_wdata (r_addr),
        .i_re    (i_cmd.pop_read),
        .i_raddr (head[NODE_AW-1:0]),
        .o_rdata (addr_rdata)
    );

    // Control state: configuration, holdings, spare list, bin valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled   <= scbc_pkg::ENABLED_RESET;
            r_budget    <= scbc_pkg::BUDGET_RESET;
            r_held      <= '0;
            r_spare     <= '0;
            r_fresh     <= '0;
            r_bin_valid <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    scbc_pkg::CFG_CACHE_ENABLED: r_enabled <= i_cfg_data[0];
                    scbc_pkg::CFG_BUDGET_BYTES:  r_budget  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (i_cmd.push) begin
                r_held             <= held_sum[HELD_W-1:0];
                r_bin_valid[r_bin] <= 1'b1;
                // a never-used node links to the next fresh one
                if (spare_fresh) begin
                    r_spare <= r_spare + NODE_W'(1);
                    r_fresh <= r_spare + NODE_W'(1);
                end else begin
                    r_spare <= link_rdata;
                end
            end
            if (i_cmd.pop_write) begin
                r_held             <= held_less;
                r_bin_valid[r_bin] <= 1'b1;
                r_spare            <= r_head;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_alloc      <= is_alloc;
            r_usable     <= r_enabled && fits && is_sized;
            r_cls        <= cls;
            r_cls_out    <= is_sized ? cls : '0;
            r_bin        <= in_bin;
            r_addr       <= i_req_addr;
            r_head_valid <= r_bin_valid[in_bin];
        end
        if (i_cmd.pop_read) begin
            r_head <= head;
        end
        if (i_cmd.pass) begin
            r_res_served <= 1'b0;
            r_res_block  <= '0;
        end
        if (i_cmd.push) begin
            r_res_served <= 1'b1;
            r_res_block  <= '0;
        end
        if (i_cmd.pop_write) begin
            r_res_served <= 1'b1;
            r_res_block  <= addr_rdata;
        end
        if (i_cmd.load_out) begin
            r_served       <= r_res_served;
            r_block_out    <= r_res_block;
            r_class_bytes  <= r_cls_out;
            r_cached_total <= r_held;
        end
    end

    assign o_served       = r_served;
    assign o_block_out    = r_block_out;
    assign o_class_bytes  = r_class_bytes;
    assign o_cached_total = r_cached_total;

    a_spare_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spare <= r_fresh)
        else $error("spare head beyond fresh mark");

    a_push_node: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> (r_held <= $past(r_budget)))
        else $error("push exceeded byte budget");
endmodule

/* sim/cache_check_pkg.sv */
// Reply tracker for the size-class block cache: predicts and checks every reply beat.
package cache_check_pkg;

    localparam int GRANULE_BYTES   = 128;
    localparam int MAX_CLASS_BYTES = 8 * 1024;
    localparam int BIN_COUNT       = 64;
    localparam int NODE_COUNT      = 1024;
    localparam int ADDR_W          = 48;
    localparam int BUDGET_FULL     = 128 * 1024;

    localparam int KIND_W     = scbc_pkg::KIND_W;
    localparam int SIZE_W     = scbc_pkg::SIZE_W;
    localparam int CLASS_W    = scbc_pkg::CLASS_W;
    localparam int HELD_W     = scbc_pkg::HELD_W;
    localparam int CFG_IDX_W  = scbc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W = scbc_pkg::CFG_DATA_W;

    localparam logic [KIND_W-1:0] KIND_FREE_UNSIZED = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNDEFINED    = 2'd3;

    typedef struct {
        bit                served;
        bit [ADDR_W-1:0]   block;
        bit [CLASS_W-1:0]  class_bytes;
        bit [HELD_W-1:0]   total;
    } t_cache_reply;

    class reply_tracker;
        // Mirror of the cache: one LIFO stack of addresses per class
        bit [ADDR_W-1:0] class_stacks [BIN_COUNT][$];
        int unsigned     nodes_used;
        int unsigned     held;
        bit              enabled;
        int unsigned     budget;

        t_cache_reply    pending_replies[$];
        int unsigned     errors;
        int unsigned     hits;
        int unsigned     kept;
        int unsigned     passed;

        function new();
            nodes_used = 0;
            held       = 0;
            enabled    = scbc_pkg::ENABLED_RESET;
            budget     = 32'(scbc_pkg::BUDGET_RESET);
            errors     = 0;
            hits       = 0;
            kept       = 0;
            passed     = 0;
        endfunction

        function void set_config(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == scbc_pkg::CFG_CACHE_ENABLED) begin
                enabled = data[0];
            end else if (idx == scbc_pkg::CFG_BUDGET_BYTES) begin
                budget = 32'(data);
            end
        endfunction

        function int pending();
            return pending_replies.size();
        endfunction

        // Pick a class that currently holds blocks, or -1 when all are empty
        function int stocked_class();
            int found[$];
            for (int b = 0; b < BIN_COUNT; b++) begin
                if (class_stacks[b].size() > 0) found.push_back(b);
            end
            if (found.size() == 0) return -1;
            return found[$urandom_range(0, found.size() - 1)];
        endfunction

        // Advance the mirror by one accepted request and queue its reply
        function void note_request(logic [KIND_W-1:0] kind, logic [SIZE_W-1:0] nbytes,
                                   logic [ADDR_W-1:0] addr);
            t_cache_reply r;
            int unsigned  s;
            int unsigned  cls;
            int unsigned  slot;
            r.served      = 0;
            r.block       = '0;
            r.class_bytes = '0;
            s   = (nbytes == '0) ? 1 : 32'(nbytes);
            cls = ((s + GRANULE_BYTES - 1) / GRANULE_BYTES) * GRANULE_BYTES;
            if (kind == scbc_pkg::KIND_ALLOC || kind == scbc_pkg::KIND_FREE_SIZED) begin
                r.class_bytes = CLASS_W'(cls);
                if (enabled && cls <= MAX_CLASS_BYTES) begin
                    slot = cls / GRANULE_BYTES - 1;
                    if (kind == scbc_pkg::KIND_ALLOC) begin
                        if (class_stacks[slot].size() > 0) begin
                            r.block = class_stacks[slot].pop_back();
                            held = (held >= cls) ? held - cls : 0;
                            nodes_used--;
                            r.served = 1;
                            hits++;
                        end
                    end else if (held + cls <= budget && nodes_used < NODE_COUNT) begin
                        class_stacks[slot].push_back(addr);
                        held += cls;
                        nodes_used++;
                        r.served = 1;
                        kept++;
                    end
                end
            end
            if (!r.served) passed++;
            r.total = HELD_W'(held);
            pending_replies.push_back(r);
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= 10) $display("%s", msg);
        endfunction

        // Compare one reply beat against the oldest prediction
        function void check_reply(logic served, logic [ADDR_W-1:0] block,
                                  logic [CLASS_W-1:0] class_bytes, logic [HELD_W-1:0] total);
            t_cache_reply e;
            if (pending_replies.size() == 0) begin
                report($sformatf("reply with nothing pending: served=%0d block=%h class=%0d total=%0d",
                                 served, block, class_bytes, total));
                return;
            end
            e = pending_replies.pop_front();
            if (served !== e.served || block !== e.block ||
                class_bytes !== e.class_bytes || total !== e.total) begin
                report($sformatf({"reply mismatch: expected served=%0d block=%h class=%0d ",
                                  "total=%0d, got served=%0d block=%h class=%0d total=%0d"},
                                 e.served, e.block, e.class_bytes, e.total,
                                 served, block, class_bytes, total));
            end
        endfunction

        function void flag_leftovers();
            if (pending_replies.size() != 0) begin
                report($sformatf("%0d replies never arrived", pending_replies.size()));
            end
        endfunction
    endclass

endpackage

/* sim/testbench.sv */
// Top-level testbench of the size-class block cache: stimulus, handshakes and end of run.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADDR_W        = cache_check_pkg::ADDR_W;
    localparam int KIND_W        = scbc_pkg::KIND_W;
    localparam int SIZE_W        = scbc_pkg::SIZE_W;
    localparam int CFG_IDX_W     = scbc_pkg::CFG_IDX_W;
    localparam int CFG_DATA_W    = scbc_pkg::CFG_DATA_W;
    localparam int GRANULE_BYTES = cache_check_pkg::GRANULE_BYTES;
    localparam int BIN_COUNT     = cache_check_pkg::BIN_COUNT;
    localparam int BUDGET_FULL   = cache_check_pkg::BUDGET_FULL;

    // Hard limit well above the slowest correct run; leave a wide margin
    localparam int CYCLE_LIMIT  = 600_000;
    // Settling time past the last reply before touching a register or ending
    localparam int SETTLE_CYCLES = 8;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    scbc_req_if #(.ADDRESS_BITS(ADDR_W)) req_ch ();
    scbc_rsp_if #(.ADDRESS_BITS(ADDR_W)) rsp_ch ();

    size_class_block_cache dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    cache_check_pkg::reply_tracker tracker = new();

    int unsigned cycle_count = 0;
    int unsigned accepted    = 0;
    int unsigned reg_writes  = 0;
    // High while both sides run back to back with no gaps
    bit          steady      = 0;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Hard stop if the block hangs
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("testbench: done, errors");
        $finish;
    end

    // Mostly short gaps, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 85) return $urandom_range(1, 3);
        if (p < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Reply side: stall at random unless a steady stretch is on
    initial begin
        int stall;
        stall = 0;
        rsp_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (!steady && $urandom_range(0, 3) == 0) stall = gap_len();
            end
        end
    end

    // Check every reply beat taken at a rising edge
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            tracker.check_reply(rsp_ch.served, rsp_ch.block_out,
                                rsp_ch.class_bytes, rsp_ch.cached_total);
        end
    end

    // Offer one request beat; hold valid across back-to-back beats
    task automatic send_req(input logic [KIND_W-1:0] kind, input logic [SIZE_W-1:0] nbytes,
                            input logic [ADDR_W-1:0] addr);
        int gap;
        gap = steady ? 0 : gap_len();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= kind;
        req_ch.size_bytes    <= nbytes;
        req_ch.block_address <= addr;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        tracker.note_request(kind, nbytes, addr);
        accepted++;
    endtask

    // Drop valid and hold off until every predicted reply has come back
    task automatic drain();
        req_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= CFG_DATA_W'(data);
        @(posedge i_clk);
        tracker.set_config(idx, CFG_DATA_W'(data));
        i_cfg_we    <= 1'b0;
        reg_writes++;
    endtask

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [63:0] a;
        a = {$urandom, $urandom};
        return a[ADDR_W-1:0];
    endfunction

    // One random request; free_pct sets the share of sized frees
    task automatic random_item(input int free_pct);
        int                pick;
        int                stocked;
        logic [KIND_W-1:0] kind;
        logic [SIZE_W-1:0] nbytes;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            kind = cache_check_pkg::KIND_FREE_UNSIZED;
        end else if (pick < 11) begin
            kind = cache_check_pkg::KIND_UNDEFINED;
        end else if (pick < 11 + free_pct) begin
            kind = scbc_pkg::KIND_FREE_SIZED;
        end else begin
            kind = scbc_pkg::KIND_ALLOC;
        end
        // Steer allocates toward classes that hold blocks so hits are common
        stocked = tracker.stocked_class();
        pick    = $urandom_range(0, 99);
        if (kind == scbc_pkg::KIND_ALLOC && pick < 55 && stocked >= 0) begin
            nbytes = SIZE_W'(stocked * GRANULE_BYTES + $urandom_range(1, GRANULE_BYTES));
        end else if (pick < 75) begin
            nbytes = SIZE_W'($urandom_range(0, 7) * GRANULE_BYTES
                             + $urandom_range(1, GRANULE_BYTES));
        end else if (pick < 90) begin
            nbytes = SIZE_W'($urandom_range(0, BIN_COUNT - 1) * GRANULE_BYTES
                             + $urandom_range(1, GRANULE_BYTES));
        end else if (pick < 93) begin
            nbytes = '0;
        end else begin
            // Full-width size, nearly always past the largest class
            nbytes = SIZE_W'($urandom);
        end
        send_req(kind, nbytes, rand_addr());
    endtask

    task automatic random_run(input int count, input int free_pct);
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
            random_item(free_pct);
        end
        steady = 0;
    endtask

    initial begin
        logic [ADDR_W-1:0] ones;
        ones = '1;

        // Every input known from time zero
        i_rst_n              <= 1'b0;
        i_cfg_we             <= 1'b0;
        i_cfg_index          <= scbc_pkg::CFG_CACHE_ENABLED;
        i_cfg_data           <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.kind          <= scbc_pkg::KIND_ALLOC;
        req_ch.size_bytes    <= '0;
        req_ch.block_address <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: size zero, class edges, LIFO order, oversized and odd kinds
        send_req(scbc_pkg::KIND_ALLOC,       24'd0,       '0);   // miss on an empty class
        send_req(scbc_pkg::KIND_FREE_SIZED,  24'd0,       ones); // size zero: first class
        send_req(scbc_pkg::KIND_ALLOC,       24'd1,       '0);   // hit gives all-ones address
        send_req(scbc_pkg::KIND_FREE_SIZED,  24'd128,     '0);
        send_req(scbc_pkg::KIND_FREE_SIZED,  24'd129,     48'h1234_5678_9ABC);
        send_req(scbc_pkg::KIND_ALLOC,       24'd256,     ones);
        send_req(scbc_pkg::KIND_ALLOC,       24'd128,     ones);
        send_req(scbc_pkg::KIND_FREE_SIZED,  24'd8192,    48'hAAAA_AAAA_AAAA);
        send_req(scbc_pkg::KIND_FREE_SIZED,  24'd8191,    48'h5555_5555_5555);
        send_req(scbc_pkg::KIND_ALLOC,       24'd8192,    '0);   // newest block first
        send_req(scbc_pkg::KIND_ALLOC,       24'd8100,    '0);
        send_req(scbc_pkg::KIND_FREE_SIZED,  24'd8193,    ones); // first class past the cache
        send_req(scbc_pkg::KIND_ALLOC,       24'd8193,    '0);
        send_req(scbc_pkg::KIND_ALLOC,       24'hFF_FFFF, '0);   // largest class size
        send_req(scbc_pkg::KIND_FREE_SIZED,  24'hFF_FFFF, ones);
        send_req(cache_check_pkg::KIND_FREE_UNSIZED, 24'hFF_FFFF, ones); // never caches
        send_req(cache_check_pkg::KIND_UNDEFINED,    24'd64,      ones); // ignored kind
        send_req(scbc_pkg::KIND_ALLOC,       24'd4096,    '0);
        send_req(scbc_pkg::KIND_FREE_SIZED,  24'd1,       48'd5);
        send_req(scbc_pkg::KIND_FREE_SIZED,  24'd100,     48'd6);
        send_req(scbc_pkg::KIND_FREE_SIZED,  24'd128,     48'd7);
        send_req(scbc_pkg::KIND_ALLOC,       24'd50,      '0);
        send_req(scbc_pkg::KIND_ALLOC,       24'd127,     '0);
        send_req(scbc_pkg::KIND_ALLOC,       24'd2,       '0);

        // Default settings, with one full pause halfway
        random_run(90, 45);
        drain();
        random_run(90, 45);

        // Push the cache up against the full budget, then keep freeing
        for (int n = 0; n < 20; n++) begin
            send_req(scbc_pkg::KIND_FREE_SIZED, 24'd8192, rand_addr());
        end
        random_run(60, 70);

        // Budget below current holdings: frees pass until allocates make room
        write_reg(scbc_pkg::CFG_BUDGET_BYTES, 4096);
        random_run(80, 30);

        // Cache off: everything passes through, holdings stay put
        write_reg(scbc_pkg::CFG_CACHE_ENABLED, 0);
        random_run(50, 45);

        // Back on with no budget at all
        write_reg(scbc_pkg::CFG_CACHE_ENABLED, 1);
        write_reg(scbc_pkg::CFG_BUDGET_BYTES, 0);
        random_run(60, 30);

        write_reg(scbc_pkg::CFG_BUDGET_BYTES, $urandom_range(0, BUDGET_FULL));
        random_run(100, 50);

        write_reg(scbc_pkg::CFG_BUDGET_BYTES, BUDGET_FULL);
        random_run(100, 50);

        // Wait out the last replies and catch any stray beat
        drain();
        repeat (4 * SETTLE_CYCLES) @(posedge i_clk);
        tracker.flag_leftovers();

        $display("covered %0d requests across %0d register writes (budget 0 to full, cache off)",
                 accepted, reg_writes);
        $display("allocate hits %0d, blocks kept %0d, passed through %0d",
                 tracker.hits, tracker.kept, tracker.passed);
        if (tracker.errors == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
